@@ hw/rtl/iecho_pkg.sv @@
// ----------------------------------------------------------------------------
// iecho_pkg
// Shared types and constants of the ICMP echo responder.
// ----------------------------------------------------------------------------
package iecho_pkg;

	// largest ICMP message that fits an Ethernet frame behind an IPv4 header
	localparam int MSG_LIMIT   = 1518 - 14 - 20;
	localparam int MAX_MSG_DEF = 64;
	localparam int LEN_W       = $clog2(MSG_LIMIT + 1);
	localparam int MIN_MSG     = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
	localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

	typedef enum logic [2:0] {
		ST_REPLY_SENT = 3'd0,
		ST_RECORDED   = 3'd1,
		ST_TOO_SHORT  = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_OTHER_TYPE = 3'd4
	} status_t;

	typedef struct packed {
		status_t           code;
		logic [LEN_W-1:0]  len;
		logic [15:0]       csum;
		logic [15:0]       id;
		logic [15:0]       seq;
		logic [31:0]       addr;
	} job_t;

endpackage

@@ hw/rtl/iecho_ram.sv @@
// ----------------------------------------------------------------------------
// iecho_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module iecho_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/iecho_queue.sv @@
// ----------------------------------------------------------------------------
// iecho_queue
// Short job queue between the receive front end and the replay back end.
// ----------------------------------------------------------------------------
module iecho_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iecho_pkg::job_t   push_job,
	input  logic              pop,
	output iecho_pkg::job_t   head,
	output logic              full,
	output logic              empty
);

	localparam int DEPTH = iecho_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	iecho_pkg::job_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign head  = slot_q[rd_ptr_q];
	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/iecho_front.sv @@
// ----------------------------------------------------------------------------
// iecho_front
// Receives message bytes, buffers them, keeps the running checksum and
// classifies the message on its last byte into a job.
// ----------------------------------------------------------------------------
module iecho_front #(
	parameter int MAX_MSG = iecho_pkg::MAX_MSG_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [7:0]                 in_byte,
	input  logic                       in_last,
	input  logic [31:0]                src_addr,
	output logic                       busy,
	input  logic                       q_full,
	input  logic                       reply_done,
	output logic                       push,
	output iecho_pkg::job_t            push_job,
	output logic                       ram_we,
	output logic [$clog2(MAX_MSG)-1:0] ram_waddr,
	output logic [7:0]                 ram_wdata
);

	localparam int CNT_W  = $clog2(MAX_MSG + 1);
	localparam int ADDR_W = $clog2(MAX_MSG);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MSG);
	localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(iecho_pkg::MIN_MSG);

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [15:0]      sum_q;
	logic [7:0]       type_q;
	logic [15:0]      id_q;
	logic [15:0]      seq_q;
	logic             reply_pend_q;

	logic             acc;
	logic [CNT_W-1:0] cnt_n;
	logic             ovf_n;
	logic [15:0]      sum_n;
	logic [7:0]       type_n;
	logic [15:0]      id_n;
	logic [15:0]      seq_n;
	logic [15:0]      addv;
	logic [16:0]      sum_raw;
	iecho_pkg::status_t code;

	assign busy      = q_full | reply_pend_q;
	assign acc       = start & ~busy;
	assign ram_we    = acc & (cnt_q != MAX_CNT);
	assign ram_waddr = cnt_q[ADDR_W-1:0];
	assign ram_wdata = in_byte;
	assign push      = acc & in_last;

	always_comb begin
		cnt_n  = cnt_q;
		ovf_n  = ovf_q;
		sum_n  = sum_q;
		type_n = type_q;
		id_n   = id_q;
		seq_n  = seq_q;
		addv    = cnt_q[0] ? {8'h00, in_byte} : {in_byte, 8'h00};
		sum_raw = {1'b0, sum_q} + {1'b0, addv};
		if (acc) begin
			if (cnt_q == MAX_CNT) begin
				ovf_n = 1'b1;
			end else begin
				cnt_n = cnt_q + 1'b1;
				if (cnt_q >= CNT_W'(4)) begin
					// end-around carry keeps a 16-bit one's-complement sum
					sum_n = sum_raw[15:0] + {15'b0, sum_raw[16]};
				end
				if (cnt_q == CNT_W'(0)) type_n = in_byte;
				if (cnt_q == CNT_W'(4)) id_n[15:8] = in_byte;
				if (cnt_q == CNT_W'(5)) id_n[7:0] = in_byte;
				if (cnt_q == CNT_W'(6)) seq_n[15:8] = in_byte;
				if (cnt_q == CNT_W'(7)) seq_n[7:0] = in_byte;
			end
		end
		if (cnt_n < MIN_CNT) begin
			code = iecho_pkg::ST_TOO_SHORT;
		end else if (ovf_n) begin
			code = iecho_pkg::ST_TOO_LONG;
		end else if (type_n == iecho_pkg::TYPE_ECHO_REQUEST) begin
			code = iecho_pkg::ST_REPLY_SENT;
		end else if (type_n == iecho_pkg::TYPE_ECHO_REPLY) begin
			code = iecho_pkg::ST_RECORDED;
		end else begin
			code = iecho_pkg::ST_OTHER_TYPE;
		end
		push_job.code = code;
		push_job.len  = iecho_pkg::LEN_W'(cnt_n);
		push_job.csum = ~sum_n;
		push_job.id   = id_n;
		push_job.seq  = seq_n;
		push_job.addr = src_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			sum_q        <= '0;
			type_q       <= '0;
			id_q         <= '0;
			seq_q        <= '0;
			reply_pend_q <= 1'b0;
		end else begin
			type_q <= type_n;
			id_q   <= id_n;
			seq_q  <= seq_n;
			if (push) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				sum_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
				sum_q <= sum_n;
			end
			if (push && code == iecho_pkg::ST_REPLY_SENT) begin
				reply_pend_q <= 1'b1;
			end else if (reply_done) begin
				reply_pend_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/iecho_back.sv @@
// ----------------------------------------------------------------------------
// iecho_back
// Carries out queued jobs: replays echo requests as replies from the buffer,
// records echo replies and emits status results.
// ----------------------------------------------------------------------------
module iecho_back #(
	parameter int MAX_MSG = iecho_pkg::MAX_MSG_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  iecho_pkg::job_t            head,
	output logic                       pop,
	output logic                       reply_done,
	output logic [$clog2(MAX_MSG)-1:0] ram_raddr,
	input  logic [7:0]                 ram_rdata,
	output logic                       out_valid,
	output logic                       is_reply_byte,
	output logic [7:0]                 out_byte,
	output logic                       out_last,
	output logic [31:0]                dest_addr,
	output logic [2:0]                 status,
	output logic [31:0]                replies_seen,
	output logic [15:0]                recorded_id,
	output logic [15:0]                recorded_seq
);

	localparam int CNT_W  = $clog2(MAX_MSG + 1);
	localparam int ADDR_W = $clog2(MAX_MSG);

	typedef enum logic [1:0] {
		B_IDLE   = 2'b01,
		B_REPLAY = 2'b10
	} back_state_t;

	back_state_t      state_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] last_idx_q;
	logic [15:0]      csum_q;
	logic [31:0]      addr_q;
	logic             valid_s1;
	logic             last_s1;
	logic [ADDR_W-1:0] idx_s1;

	logic             out_valid_q;
	logic             is_reply_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic [31:0]      dest_q;
	iecho_pkg::status_t status_q;
	logic [31:0]      replies_q;
	logic [15:0]      id_q;
	logic [15:0]      seq_q;

	logic [CNT_W-1:0] len_m1;
	logic             issue_last;
	logic [7:0]       reply_byte;

	assign pop        = (state_q == B_IDLE) & ~q_empty & ~valid_s1;
	assign len_m1     = head.len[CNT_W-1:0] - 1'b1;
	assign issue_last = (state_q == B_REPLAY) & (idx_q == last_idx_q);
	assign reply_done = issue_last;
	assign ram_raddr  = idx_q;

	always_comb begin
		case (idx_s1)
			ADDR_W'(0): reply_byte = iecho_pkg::TYPE_ECHO_REPLY;
			ADDR_W'(1): reply_byte = 8'h00;
			ADDR_W'(2): reply_byte = csum_q[15:8];
			ADDR_W'(3): reply_byte = csum_q[7:0];
			default:    reply_byte = ram_rdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_idx_q <= len_m1[ADDR_W-1:0];
			csum_q     <= head.csum;
			addr_q     <= head.addr;
		end
		idx_s1  <= idx_q;
		last_s1 <= issue_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			is_reply_q  <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			dest_q      <= '0;
			status_q    <= iecho_pkg::ST_REPLY_SENT;
			replies_q   <= '0;
			id_q        <= '0;
			seq_q       <= '0;
		end else begin
			valid_s1    <= (state_q == B_REPLAY);
			out_valid_q <= valid_s1 | (pop & (head.code != iecho_pkg::ST_REPLY_SENT));
			case (state_q)
				B_IDLE: begin
					idx_q <= '0;
					if (pop) begin
						if (head.code == iecho_pkg::ST_REPLY_SENT) begin
							state_q <= B_REPLAY;
						end else begin
							is_reply_q  <= 1'b0;
							out_byte_q  <= '0;
							out_last_q  <= 1'b1;
							dest_q      <= '0;
							status_q    <= head.code;
							if (head.code == iecho_pkg::ST_RECORDED) begin
								replies_q <= replies_q + 1'b1;
								id_q      <= head.id;
								seq_q     <= head.seq;
							end
						end
					end
				end
				B_REPLAY: begin
					idx_q <= idx_q + 1'b1;
					if (issue_last) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (valid_s1) begin
				is_reply_q  <= 1'b1;
				out_byte_q  <= reply_byte;
				out_last_q  <= last_s1;
				dest_q      <= addr_q;
				status_q    <= iecho_pkg::ST_REPLY_SENT;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign is_reply_byte = is_reply_q;
	assign out_byte      = out_byte_q;
	assign out_last      = out_last_q;
	assign dest_addr     = dest_q;
	assign status        = status_q;
	assign replies_seen  = replies_q;
	assign recorded_id   = id_q;
	assign recorded_seq  = seq_q;

endmodule

@@ hw/rtl/icmp_echo_responder.sv @@
// ----------------------------------------------------------------------------
// icmp_echo_responder
// Input: one message byte per cycle while busy is low.
// Status results are registered once the job is taken from the job queue;
// a reply passes the replay state, the buffer read and the read stage, then
// streams one byte per cycle. After a request busy stays high while the reply
// is read back from the message buffer, which holds a single message.
// Reset clears control state and counters; the message buffer is not cleared.
// ----------------------------------------------------------------------------
module icmp_echo_responder #(
	parameter int MAX_MSG = iecho_pkg::MAX_MSG_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	input  logic [31:0] src_addr,
	output logic        out_valid,
	output logic        is_reply_byte,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [31:0] dest_addr,
	output logic [2:0]  status,
	output logic [31:0] replies_seen,
	output logic [15:0] recorded_id,
	output logic [15:0] recorded_seq
);

	localparam int ADDR_W = $clog2(MAX_MSG);

	logic              q_full;
	logic              q_empty;
	logic              push;
	logic              pop;
	logic              reply_done;
	iecho_pkg::job_t   push_job;
	iecho_pkg::job_t   head;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	iecho_front #(.MAX_MSG(MAX_MSG)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.src_addr   (src_addr),
		.busy       (busy),
		.q_full     (q_full),
		.reply_done (reply_done),
		.push       (push),
		.push_job   (push_job),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	iecho_ram #(.WIDTH(8), .DEPTH(MAX_MSG)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iecho_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	iecho_back #(.MAX_MSG(MAX_MSG)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head          (head),
		.pop           (pop),
		.reply_done    (reply_done),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.is_reply_byte (is_reply_byte),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.dest_addr     (dest_addr),
		.status        (status),
		.replies_seen  (replies_seen),
		.recorded_id   (recorded_id),
		.recorded_seq  (recorded_seq)
	);

	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_reply_byte |-> out_last && out_byte == 8'h00 && dest_addr == 32'h0)
		else $error("status result carries reply payload");

	a_count_on_record: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(replies_seen) |-> out_valid &&
			status == iecho_pkg::ST_RECORDED)
		else $error("reply count changed without a recorded echo reply");

	a_reply_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_reply_byte && !out_last |=> out_valid && is_reply_byte)
		else $error("gap inside a reply stream");

	a_reply_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_reply_byte && out_last |=> !(out_valid && is_reply_byte))
		else $error("reply byte right after end of reply");

endmodule
